### hdl/assert_macros.svh
// Assertion macros shared by the matrix ALU RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

### hdl/m2alu_pkg.sv
// Package for the 2x2 matrix ALU: opcodes, widths and the queued item type.
// No dependencies.
`default_nettype none
package m2alu_pkg;
   localparam int DW = 32;
   localparam int FB = 16;
   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_MVEC = 3'd3,
      OP_TRN = 3'd4, OP_DET = 3'd5, OP_INV = 3'd6, OP_NONE = 3'd7
   } op_type;
   typedef logic signed [DW-1:0] word_type;
   typedef struct packed {
      op_type   op;
      word_type a11, a12, a21, a22, b11, b12, b21, b22;
   } item_type;
   typedef struct packed {
      word_type r11, r12, r21, r22, det;
      logic     sing;
   } result_type;
endpackage
`default_nettype wire

### hdl/m2alu_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing but its type parameter.
`default_nettype none
interface m2alu_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/m2alu_front.sv
// Front end: accepts transactions and holds them in a two-entry queue.
// Depends on m2alu_pkg.
`default_nettype none
module m2alu_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire m2alu_pkg::item_type in_data,
   output logic                    q_valid,
   input  wire logic               q_ready,
   output m2alu_pkg::item_type     q_data
);
   import m2alu_pkg::*;
   item_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   `include "assert_macros.svh"
   `CHK_NEXT(a_full_no_push, clock, reset, cnt_ff == 2'd2 && !pop, cnt_ff == 2'd2)
   `CHK_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
   `CHK_IMPL(a_ptr_match, clock, reset, cnt_ff == 2'd0, wp_ff == rp_ff)
endmodule
`default_nettype wire

### hdl/m2alu_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage.
// Computes round(num * 2^FB / den), halves away from zero, saturated.
// Depends on m2alu_pkg.
`default_nettype none
module m2alu_div (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic signed [m2alu_pkg::DW:0] num,
   input  wire logic signed [m2alu_pkg::DW-1:0] den,
   output m2alu_pkg::word_type           quo
);
   import m2alu_pkg::*;
   // Magnitude of num << FB plus half the divisor.
   localparam int NW = DW + 1 + FB + 1;
   localparam int RW = DW + 1;
   logic [NW-1:0] m_ff [NW+1];
   logic [NW-1:0] q_ff [NW+1];
   logic [RW-1:0] r_ff [NW+1];
   logic [DW-1:0] d_ff [NW+1];
   logic          neg_ff [NW+1];
   logic [DW-1:0] dmag;
   logic [DW:0]   nmag;
   logic signed [NW:0] qs;

   assign dmag = den[DW-1] ? DW'(-den) : DW'(den);
   assign nmag = num[DW] ? (DW+1)'(-num) : (DW+1)'(num);

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= NW'({nmag, FB'(0)}) + NW'(dmag >> 1);
         q_ff[0] <= '0;
         r_ff[0] <= '0;
         d_ff[0] <= dmag;
         neg_ff[0] <= num[DW] ^ den[DW-1];
      end
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [RW:0] rt;
      logic        ge;
      assign rt = {r_ff[s], m_ff[s][NW-1-s]};
      assign ge = (rt >= {2'b00, d_ff[s]});
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[s+1] <= m_ff[s];
            d_ff[s+1] <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            q_ff[s+1] <= q_ff[s] | (NW'(ge) << (NW - 1 - s));
            r_ff[s+1] <= ge ? RW'(rt - {2'b00, d_ff[s]}) : RW'(rt);
         end
      end
   end

   always_comb begin
      qs = neg_ff[NW] ? -$signed({1'b0, q_ff[NW]}) : $signed({1'b0, q_ff[NW]});
      if (qs > $signed((NW+1)'({1'b0, {(DW-1){1'b1}}}))) begin
         quo = {1'b0, {(DW-1){1'b1}}};
      end else if (qs < -$signed((NW+1)'({1'b1, {(DW-1){1'b0}}}))) begin
         quo = {1'b1, {(DW-1){1'b0}}};
      end else begin
         quo = DW'(qs);
      end
   end
endmodule
`default_nettype wire

### hdl/m2alu_back.sv
// Back end: fixed-depth stall-together pipeline computing all operations.
// Stage 1 products and sums, stage 2 rounding and determinant, then divider.
// Depends on m2alu_pkg and m2alu_div.
`default_nettype none
module m2alu_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_ready,
   input  wire m2alu_pkg::item_type  q_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output m2alu_pkg::result_type     out_data
);
   import m2alu_pkg::*;
   localparam int PW = 2 * DW;
   localparam int DVL = DW + FB + 3;
   localparam int LAT = 2 + DVL;
   logic [LAT-1:0] v_ff;
   logic           en;
   logic signed [PW-1:0] p_ff [10];
   word_type  s_ff [4];
   word_type  s_in [4];
   item_type  i1_ff;
   word_type  d2r_ff [4];
   word_type  d2r_in [4];
   word_type  det2_ff;
   logic      sing2_ff;
   op_type    op2_ff;
   item_type  i2_ff;
   logic signed [DW:0] adj [4];
   word_type  quo [4];
   word_type  dly_r_ff [LAT-2][4];
   word_type  dly_det_ff [LAT-2];
   logic      dly_sing_ff [LAT-2];
   op_type    dly_op_ff [LAT-2];
   word_type  dot [4];
   word_type  det_c;

   // The pipeline advances whenever its last stage is empty or drained.
   assign en = !v_ff[LAT-1] || out_ready;
   assign q_ready = en;
   assign out_valid = v_ff[LAT-1];

   function automatic word_type sat_w(input logic signed [PW+1:0] x);
      if (x > $signed((PW+2)'({1'b0, {(DW-1){1'b1}}}))) begin
         return {1'b0, {(DW-1){1'b1}}};
      end else if (x < -$signed((PW+2)'({1'b1, {(DW-1){1'b0}}}))) begin
         return {1'b1, {(DW-1){1'b0}}};
      end
      return DW'(x);
   endfunction

   function automatic word_type rnd_dot(input logic signed [PW-1:0] p,
                                        input logic signed [PW-1:0] q);
      logic signed [PW+1:0] s;
      s = (PW+2)'(p) + (PW+2)'(q) + (PW+2)'(1 << (FB - 1));
      return sat_w(s >>> FB);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], q_valid};
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s_in[k] = '0;
      end
      if (q_data.op inside {OP_ADD, OP_SUB}) begin
         s_in[0] = sat_w((q_data.op == OP_SUB)
            ? (PW+2)'(q_data.a11) - (PW+2)'(q_data.b11)
            : (PW+2)'(q_data.a11) + (PW+2)'(q_data.b11));
         s_in[1] = sat_w((q_data.op == OP_SUB)
            ? (PW+2)'(q_data.a12) - (PW+2)'(q_data.b12)
            : (PW+2)'(q_data.a12) + (PW+2)'(q_data.b12));
         s_in[2] = sat_w((q_data.op == OP_SUB)
            ? (PW+2)'(q_data.a21) - (PW+2)'(q_data.b21)
            : (PW+2)'(q_data.a21) + (PW+2)'(q_data.b21));
         s_in[3] = sat_w((q_data.op == OP_SUB)
            ? (PW+2)'(q_data.a22) - (PW+2)'(q_data.b22)
            : (PW+2)'(q_data.a22) + (PW+2)'(q_data.b22));
      end
   end

   // Stage 1: ten products and the four sums or differences.
   always_ff @(posedge clock) begin
      if (en) begin
         i1_ff <= q_data;
         p_ff[0] <= (q_data.op inside {OP_MUL, OP_MVEC})
                    ? q_data.a11 * q_data.b11 : q_data.a11 * q_data.a22;
         p_ff[1] <= (q_data.op inside {OP_MUL, OP_MVEC})
                    ? q_data.a12 * q_data.b21 : -(q_data.a12 * q_data.a21);
         p_ff[2] <= q_data.a11 * q_data.b12;
         p_ff[3] <= q_data.a12 * q_data.b22;
         p_ff[4] <= q_data.a21 * q_data.b11;
         p_ff[5] <= q_data.a22 * q_data.b21;
         p_ff[6] <= q_data.a11 * q_data.a22;
         p_ff[7] <= -(q_data.a12 * q_data.a21);
         p_ff[8] <= q_data.a21 * q_data.b12;
         p_ff[9] <= q_data.a22 * q_data.b22;
         s_ff <= s_in;
      end
   end

   always_comb begin
      dot[0] = rnd_dot(p_ff[0], p_ff[1]);
      dot[1] = rnd_dot(p_ff[2], p_ff[3]);
      dot[2] = rnd_dot(p_ff[4], p_ff[5]);
      dot[3] = rnd_dot(p_ff[8], p_ff[9]);
      det_c = rnd_dot(p_ff[6], p_ff[7]);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         d2r_in[k] = '0;
      end
      case (i1_ff.op)
         OP_ADD, OP_SUB: begin
            d2r_in = s_ff;
         end
         OP_MUL: begin
            d2r_in = dot;
         end
         OP_MVEC: begin
            d2r_in[0] = dot[0];
            d2r_in[2] = dot[2];
         end
         OP_TRN: begin
            d2r_in[0] = i1_ff.a11;
            d2r_in[1] = i1_ff.a21;
            d2r_in[2] = i1_ff.a12;
            d2r_in[3] = i1_ff.a22;
         end
         default: begin
         end
      endcase
   end

   // Stage 2: rounded results and determinant, selected by opcode.
   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff <= i1_ff.op;
         i2_ff <= i1_ff;
         det2_ff <= det_c;
         sing2_ff <= (i1_ff.op == OP_INV) && (det_c == '0);
         d2r_ff <= d2r_in;
      end
   end

   assign adj[0] = (DW+1)'(i2_ff.a22);
   assign adj[1] = -(DW+1)'(i2_ff.a12);
   assign adj[2] = -(DW+1)'(i2_ff.a21);
   assign adj[3] = (DW+1)'(i2_ff.a11);

   for (genvar k = 0; k < 4; k++) begin : g_div
      m2alu_div u_div (
         .clock (clock),
         .en    (en),
         .num   (adj[k]),
         .den   ((det2_ff == '0) ? word_type'(1) : det2_ff),
         .quo   (quo[k])
      );
   end

   // Side delay line matching the divider latency.
   always_ff @(posedge clock) begin
      if (en) begin
         dly_r_ff[0] <= d2r_ff;
         dly_det_ff[0] <= det2_ff;
         dly_sing_ff[0] <= sing2_ff;
         dly_op_ff[0] <= op2_ff;
         for (int s = 1; s < LAT - 2; s++) begin
            dly_r_ff[s] <= dly_r_ff[s-1];
            dly_det_ff[s] <= dly_det_ff[s-1];
            dly_sing_ff[s] <= dly_sing_ff[s-1];
            dly_op_ff[s] <= dly_op_ff[s-1];
         end
      end
   end

   always_comb begin
      out_data.det = dly_det_ff[LAT-3];
      out_data.sing = dly_sing_ff[LAT-3];
      if (dly_op_ff[LAT-3] == OP_INV && !dly_sing_ff[LAT-3]) begin
         out_data.r11 = quo[0];
         out_data.r12 = quo[1];
         out_data.r21 = quo[2];
         out_data.r22 = quo[3];
      end else begin
         out_data.r11 = dly_r_ff[LAT-3][0];
         out_data.r12 = dly_r_ff[LAT-3][1];
         out_data.r21 = dly_r_ff[LAT-3][2];
         out_data.r22 = dly_r_ff[LAT-3][3];
      end
   end

   `include "assert_macros.svh"
   `CHK_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid)
   `CHK_IMPL(a_sing_op, clock, reset, out_valid && out_data.sing, dly_op_ff[LAT-3] == OP_INV)
   `CHK_IMPL(a_sing_zero, clock, reset, out_valid && out_data.sing, out_data.r11 == '0)
endmodule
`default_nettype wire

### hdl/matrix2x2_alu.sv
// Top level of the 2x2 matrix ALU on signed Q16.16 values.
// Channel req_ carries an opcode with matrices A and B; rsp_ returns the
// result matrix, the determinant of A and the singular flag.
// A transaction is taken when valid and ready are high at a clock edge.
// While rsp_ready is high one transaction per cycle is sustained; each
// goes through a two-entry input queue, then a back-end pipeline of
// DW+FB+5 stages (53 by default), whose length is set by the restoring
// divider used for the inverse, one quotient bit per stage. An accepted
// transaction is registered in the queue, then taken by the back end
// and carried through all of its stages to rsp_valid.
// A synchronous active-high reset empties the queue and the pipeline.
// If the receiver holds rsp_ready low while rsp_valid is high, the whole
// back end stalls, the queue fills and req_ready falls once it is full.
// Depends on m2alu_pkg, m2alu_if, m2alu_front and m2alu_back.
`default_nettype none
module matrix2x2_alu (
   input wire logic clock,
   input wire logic reset,
   m2alu_if.sink    req,
   m2alu_if.source  rsp
);
   import m2alu_pkg::*;
   logic     q_valid, q_ready;
   item_type q_data;

   m2alu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_data  (req.data),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data)
   );

   m2alu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.data)
   );
endmodule
`default_nettype wire
